FILE: rtl/bud_pkg.sv
// Shared constants and types for the buddy allocator.
// No dependencies.
package bud_pkg;

    localparam int TOP_ORDER   = 9;
    localparam int TOTAL_UNITS = 512;
    localparam int ADDR_W      = 9;
    localparam int SIZE_W      = 10;
    localparam int ORD_W       = 4;
    localparam int FLAG_W      = 10;
    localparam int PAIR_W      = 9;
    localparam int FLAG_COUNT  = 2 * TOTAL_UNITS - 1;
    localparam int PAIR_COUNT  = TOTAL_UNITS - 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    function automatic logic [FLAG_W-1:0] flag_base(input logic [ORD_W-1:0] ord);
        logic [FLAG_W-1:0] b;
        b = '0;
        for (int o = 0; o < TOP_ORDER; o++)
            if (o < int'(ord))
                b = b + FLAG_W'(TOTAL_UNITS >> o);
        return b;
    endfunction

    function automatic logic [PAIR_W-1:0] pair_base(input logic [ORD_W-1:0] ord);
        logic [PAIR_W-1:0] b;
        b = '0;
        for (int o = 0; o < TOP_ORDER; o++)
            if (o < int'(ord))
                b = b + PAIR_W'(TOTAL_UNITS >> (o + 1));
        return b;
    endfunction

endpackage

FILE: rtl/bud_flag_mem.sv
// Free-flag store: one bit per block of every order, sync read.
// Depends on bud_pkg. Reset state restored by the engine's clearing pass.
module bud_flag_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bud_pkg::FLAG_W-1:0] i_waddr,
    input  logic                      i_wdata,
    input  logic [bud_pkg::FLAG_W-1:0] i_raddr,
    output logic                      o_rdata
);
    logic r_mem [bud_pkg::FLAG_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/bud_pair_mem.sv
// Buddy pair-bit store, sync read.
// Depends on bud_pkg.
module bud_pair_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bud_pkg::PAIR_W-1:0] i_waddr,
    input  logic                      i_wdata,
    input  logic [bud_pkg::PAIR_W-1:0] i_raddr,
    output logic                      o_rdata
);
    logic r_mem [bud_pkg::PAIR_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/buddy_allocator.sv
// Top level of the buddy allocator: control sequencer over two memories.
// Depends on bud_pkg, bud_flag_mem, bud_pair_mem.
//
// channel  | dir | signals
// request  | in  | i_start, o_busy, i_operation, i_request_size, i_block_address
// result   | out | o_done, o_granted_address, o_status
//
// After reset a clearing pass runs with o_busy high.
// Allocate: a read (S_SRCH) and a check (S_SWAIT) per free-flag entry scanned, up to 1023
// entries in the flat scan; S_SPLIT per split order, then S_PRD and S_PWAIT per pair toggle.
// Free: S_PRD and S_PWAIT per pair toggle, S_MERGE per merge, then a final write
// (S_FINAL). Each request ends with one done cycle; a bad size is done the
// cycle after accept. Results cannot be stalled.
module buddy_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic [bud_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [bud_pkg::ADDR_W-1:0]    i_block_address,
    output logic                          o_done,
    output logic [bud_pkg::ADDR_W-1:0]    o_granted_address,
    output logic [1:0]                    o_status
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SRCH = 4'd2,
                           S_SWAIT = 4'd3, S_SPLIT = 4'd4, S_PRD = 4'd5,
                           S_PWAIT = 4'd6, S_MERGE = 4'd7, S_FINAL = 4'd8,
                           S_DONE = 4'd9;

    logic [3:0] r_st, n_st;
    logic [bud_pkg::FLAG_W-1:0] r_idx, n_idx;
    logic r_op, n_op;
    logic [bud_pkg::ORD_W-1:0] r_ord, n_ord, r_lvl, n_lvl, r_mcnt, n_mcnt;
    logic [bud_pkg::ADDR_W-1:0] r_addr, n_addr, r_scan, n_scan;
    logic [1:0] r_status, n_status;

    logic f_we, f_wd, f_rd, p_we, p_wd, p_rd;
    logic [bud_pkg::FLAG_W-1:0] f_wa, f_ra;
    logic [bud_pkg::PAIR_W-1:0] p_wa, p_ra;

    bud_flag_mem u_flag (.i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
                         .i_raddr(f_ra), .o_rdata(f_rd));
    bud_pair_mem u_pair (.i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
                         .i_raddr(p_ra), .o_rdata(p_rd));

    logic [bud_pkg::ORD_W-1:0] in_ord;
    logic bad_size;
    logic [bud_pkg::ADDR_W-1:0] align_mask, lvl_unit, half_unit, scan_next, buddy;
    logic [bud_pkg::FLAG_W-1:0] lvl_cnt;

    always_comb begin
        in_ord = '0;
        for (int o = bud_pkg::TOP_ORDER - 1; o >= 0; o--)
            if ({1'b0, i_request_size} > (11'd1 << o)) begin
                in_ord = bud_pkg::ORD_W'(o + 1);
                break;
            end
        bad_size   = (i_request_size == '0) ||
                     (i_request_size > bud_pkg::SIZE_W'(bud_pkg::TOTAL_UNITS));
        align_mask = ~((bud_pkg::ADDR_W'(1) << r_ord) - bud_pkg::ADDR_W'(1));
        lvl_unit   = bud_pkg::ADDR_W'(1) << r_lvl;
        half_unit  = bud_pkg::ADDR_W'(1) << (r_lvl - 1'b1);
        lvl_cnt    = bud_pkg::FLAG_W'(bud_pkg::TOTAL_UNITS) >> r_lvl;
        scan_next  = r_scan + lvl_unit;
        buddy      = r_addr ^ (bud_pkg::ADDR_W'(1) << (r_ord + r_mcnt));
    end

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_op = r_op; n_ord = r_ord; n_lvl = r_lvl;
        n_mcnt = r_mcnt; n_addr = r_addr; n_scan = r_scan; n_status = r_status;
        f_we = 1'b0; f_wd = 1'b0; f_wa = r_idx; f_ra = '0;
        p_we = 1'b0; p_wd = 1'b0; p_wa = '0; p_ra = '0;
        unique case (r_st)
            S_CLEAR: begin
                f_we = 1'b1; f_wa = r_idx;
                f_wd = (r_idx == bud_pkg::FLAG_W'(bud_pkg::FLAG_COUNT - 1));
                p_we = (r_idx < bud_pkg::FLAG_W'(bud_pkg::PAIR_COUNT));
                p_wa = r_idx[bud_pkg::PAIR_W-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == bud_pkg::FLAG_W'(bud_pkg::FLAG_COUNT - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_operation; n_ord = in_ord; n_lvl = in_ord;
                    n_scan = '0; n_mcnt = '0; n_status = bud_pkg::ST_OK;
                    n_addr = i_block_address;
                    if (bad_size) begin
                        n_status = bud_pkg::ST_BAD_SIZE; n_st = S_DONE;
                    end else if (i_operation == bud_pkg::OP_FREE) begin
                        n_st = S_PRD;
                    end else begin
                        n_st = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                f_ra = bud_pkg::flag_base(r_lvl) + bud_pkg::FLAG_W'(r_scan >> r_lvl);
                n_st = S_SWAIT;
            end
            S_SWAIT: begin
                if (f_rd) begin
                    n_addr = r_scan;
                    f_we = 1'b1; f_wd = 1'b0;
                    f_wa = bud_pkg::flag_base(r_lvl) + bud_pkg::FLAG_W'(r_scan >> r_lvl);
                    n_st = S_SPLIT;
                end else if ((bud_pkg::FLAG_W'(r_scan >> r_lvl) + 1'b1) < lvl_cnt) begin
                    n_scan = scan_next; n_st = S_SRCH;
                end else if (r_lvl < bud_pkg::ORD_W'(bud_pkg::TOP_ORDER)) begin
                    n_lvl = r_lvl + 1'b1; n_scan = '0; n_st = S_SRCH;
                end else begin
                    n_status = bud_pkg::ST_NO_SPACE; n_st = S_DONE;
                end
            end
            S_SPLIT: begin
                if (r_lvl > r_ord) begin
                    f_we = 1'b1; f_wd = 1'b1;
                    f_wa = bud_pkg::flag_base(r_lvl - 1'b1) +
                           bud_pkg::FLAG_W'((r_addr + half_unit) >> (r_lvl - 1'b1));
                    n_lvl = r_lvl - 1'b1;
                end else begin
                    n_lvl = r_ord; n_st = S_PRD;
                end
            end
            S_PRD: begin
                if (r_op == bud_pkg::OP_FREE && r_lvl == r_ord)
                    n_addr = r_addr & align_mask;
                if (r_lvl >= bud_pkg::ORD_W'(bud_pkg::TOP_ORDER)) begin
                    n_st = (r_op == bud_pkg::OP_FREE) ? S_MERGE : S_DONE;
                    n_mcnt = '0;
                end else begin
                    p_ra = bud_pkg::pair_base(r_lvl) +
                           bud_pkg::PAIR_W'((r_addr & align_mask) >> (r_lvl + 1'b1));
                    n_st = S_PWAIT;
                end
            end
            S_PWAIT: begin
                p_we = 1'b1; p_wd = ~p_rd;
                p_wa = bud_pkg::pair_base(r_lvl) + bud_pkg::PAIR_W'(r_addr >> (r_lvl + 1'b1));
                if (r_op == bud_pkg::OP_ALLOC) begin
                    if (p_rd) n_st = S_DONE;
                    else begin n_lvl = r_lvl + 1'b1; n_st = S_PRD; end
                end else begin
                    if (!p_rd) begin n_st = S_MERGE; n_mcnt = '0; end
                    else begin n_lvl = r_lvl + 1'b1; n_st = S_PRD; end
                end
            end
            S_MERGE: begin
                if (r_ord + r_mcnt < r_lvl) begin
                    f_we = 1'b1; f_wd = 1'b0;
                    f_wa = bud_pkg::flag_base(r_ord + r_mcnt) +
                           bud_pkg::FLAG_W'(buddy >> (r_ord + r_mcnt));
                    if (buddy < r_addr) n_addr = buddy;
                    n_mcnt = r_mcnt + 1'b1;
                end else n_st = S_FINAL;
            end
            S_FINAL: begin
                f_we = 1'b1; f_wd = 1'b1;
                f_wa = bud_pkg::flag_base(r_lvl) + bud_pkg::FLAG_W'(r_addr >> r_lvl);
                n_addr = '0; n_st = S_DONE;
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_idx <= '0;
        end else begin
            r_st <= n_st; r_idx <= n_idx;
        end
        r_op <= n_op; r_ord <= n_ord; r_lvl <= n_lvl; r_mcnt <= n_mcnt;
        r_addr <= n_addr; r_scan <= n_scan; r_status <= n_status;
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_done = (r_st == S_DONE);
    assign o_status = r_status;
    assign o_granted_address = (r_status == bud_pkg::ST_OK && r_op == bud_pkg::OP_ALLOC)
                               ? r_addr : '0;
endmodule

FILE: rtl/bud_checker.sv
// Port-level checks for the buddy allocator, bound to the top level.
// Depends on bud_pkg and buddy_allocator.
module bud_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic                       o_done,
    input logic [bud_pkg::ADDR_W-1:0] o_granted_address,
    input logic [1:0]                 o_status
);
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == bud_pkg::ST_OK || o_status == bud_pkg::ST_NO_SPACE ||
                    o_status == bud_pkg::ST_BAD_SIZE)) else $error("bad status");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != bud_pkg::ST_OK) |-> o_granted_address == '0)
        else $error("address on failure");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after accept");
endmodule

bind buddy_allocator bud_checker u_bud_checker (.*);
